// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/rmc_pkg.sv -----
// Shared types, constants and helper functions of the RMC time parser.
package rmc_pkg;

	localparam int LINE_CAPACITY  = 128;
	localparam int FIELD_CAPACITY = 16;
	localparam int LINE_AW        = $clog2(LINE_CAPACITY);
	localparam int FL_W           = $clog2(FIELD_CAPACITY) + 1;
	localparam int TICK_W         = 48;
	localparam int CNT_W          = 32;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam int YEAR_BASE       = 2000;
	localparam int PREV_ERA_YEAR   = 1600;
	localparam int TICKS_PER_SEC   = 10000;

	// Day offset of the 400-year era start relative to 1970-01-01.
	localparam logic [TICK_W-1:0] DAYS_ERA5 = TICK_W'(5 * 146097 - 719468);
	localparam logic [TICK_W-1:0] DAYS_ERA4 = TICK_W'(4 * 146097 - 719468);

	localparam logic [13:0] MUL_YEAR = 14'd365;
	localparam logic [13:0] MUL_DAY  = 14'd24;
	localparam logic [13:0] MUL_MIN  = 14'd60;
	localparam logic [13:0] MUL_TICK = 14'(TICKS_PER_SEC);

	typedef enum logic [2:0] {
		EV_RMC_OK    = 3'd0,
		EV_CSUM_FAIL = 3'd1,
		EV_OVERFLOW  = 3'd2,
		EV_PPS_LOCK  = 3'd3,
		EV_PPS_REJ   = 3'd4
	} event_t;

	typedef struct packed {
		logic [11:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [9:0]  milliseconds;
		logic        gps_fix;
	} stamp_t;

	typedef struct packed {
		logic               vld;
		logic [LINE_AW-1:0] pos;
		logic [7:0]         data;
	} scan_beat_t;

	typedef struct packed {
		logic   is_rmc;
		logic   csum_ok;
		logic   parse_ok;
		stamp_t stamp;
	} scan_res_t;

	typedef logic [11:0] doy_tab_t [128];

	// Days from March 1 to the first of shifted month mp.
	function automatic doy_tab_t build_doy_tab();
		doy_tab_t t;
		for (int i = 0; i < 128; i++) begin
			t[i] = 12'((153 * i + 2) / 5);
		end
		return t;
	endfunction

	localparam doy_tab_t DOY_TAB = build_doy_tab();

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic [6:0] digit_pair(input logic [7:0] a, input logic [7:0] b);
		logic [6:0] hi;
		hi = {3'b000, a[3:0]};
		return 7'(hi * 7'd10 + {3'b000, b[3:0]});
	endfunction

	// Bit 4 flags a hex character, bits 3:0 carry its value.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (is_digit(c)) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

endpackage

// ----- rtl/nmea_rmc_pps_time_parser.sv -----
// Top level of the NMEA RMC parser with PPS time discipline.
//
// Input channel (in_valid / in_stall) carries one beat per UART byte
// (cmd = 0, rx_byte) or per PPS edge (cmd = 1). Output channel
// (out_valid / out_stall) carries at most one result beat per input beat.
// in_stall is high whenever the sequencer is not idle.
// Ordinary bytes are written to the line buffer; CR and empty lines give no
// result. A line feed starts a scan of the buffer, one byte per cycle through
// its registered read port. For a line, out_valid rises after the scan and
// check when the checksum fails, and after a conversion in the shared
// multiply-add unit for an accepted sentence. A PPS beat with a valid fix
// gives its result after a conversion; a rejected pulse or an overflowing
// byte goes straight to the emit state. in_stall stays high until the
// result is loaded. A finished result sits in the output register while the
// next bytes are taken; a second result waits in the emit state until the
// receiver drops out_stall. Reset clears the line length, the stored time,
// lock and all counters; the buffer contents need no clearing.
`include "assert_macros.svh"

module nmea_rmc_pps_time_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [47:0] unix_time_100us,
	output logic [11:0] year,
	output logic [6:0]  month,
	output logic [6:0]  day,
	output logic [6:0]  hours,
	output logic [6:0]  minutes,
	output logic [6:0]  seconds,
	output logic [9:0]  milliseconds,
	output logic        gps_fix,
	output logic        locked,
	output logic [31:0] event_count
);
	import rmc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_CONV  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [LINE_AW-1:0] len_q, cnt_q;
	logic               iss_done_q;
	logic               vld_s1;
	logic [LINE_AW-1:0] pos_s1;
	event_t             ev_q;
	stamp_t             last_q;
	logic               have_q, lock_q;
	logic [TICK_W-1:0]  unix_q;
	logic [CNT_W-1:0]   cnt_ok_q, cnt_cs_q, cnt_ov_q;

	logic               out_valid_q, out_lock_q;
	event_t             out_ev_q;
	logic [TICK_W-1:0]  out_time_q;
	stamp_t             out_stamp_q;
	logic [CNT_W-1:0]   out_cnt_q;

	logic               acc, is_lf, is_cr, full, wr_en, scan_clr, emit_load;
	logic [7:0]         rd_data;
	scan_beat_t         beat;
	scan_res_t          res;
	logic               conv_go, conv_done;
	stamp_t             conv_stamp;
	logic [TICK_W-1:0]  ticks;

	assign in_stall  = (state_q != ST_IDLE);
	assign acc       = in_valid && !in_stall;
	assign is_lf     = (rx_byte == CH_LF);
	assign is_cr     = (rx_byte == CH_CR);
	assign full      = (len_q == LINE_AW'(LINE_CAPACITY - 1));
	assign wr_en     = acc && !cmd && !is_lf && !is_cr && !full;
	assign scan_clr  = acc && !cmd && is_lf && (len_q != '0);
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// A pulse converts the stored stamp; an accepted line converts the fresh one.
	assign conv_go = (acc && cmd && have_q && last_q.gps_fix) ||
		((state_q == ST_CHECK) && res.is_rmc && res.csum_ok && res.parse_ok);
	assign conv_stamp = (state_q == ST_CHECK) ? res.stamp : last_q;

	assign beat = {vld_s1, pos_s1, rd_data};

	rmc_line_buf u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (len_q),
		.wr_data (rx_byte),
		.rd_addr (cnt_q),
		.rd_data (rd_data)
	);

	rmc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (scan_clr),
		.beat   (beat),
		.res    (res)
	);

	rmc_tconv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_go),
		.pps    (state_q == ST_IDLE),
		.stamp  (conv_stamp),
		.done   (conv_done),
		.ticks  (ticks)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			iss_done_q  <= 1'b0;
			vld_s1      <= 1'b0;
			ev_q        <= EV_RMC_OK;
			last_q      <= '0;
			have_q      <= 1'b0;
			lock_q      <= 1'b0;
			unix_q      <= '0;
			cnt_ok_q    <= '0;
			cnt_cs_q    <= '0;
			cnt_ov_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (cmd) begin
							if (have_q && last_q.gps_fix) begin
								state_q <= ST_CONV;
							end else begin
								ev_q    <= EV_PPS_REJ;
								state_q <= ST_EMIT;
							end
						end else if (is_lf) begin
							if (len_q != '0) begin
								cnt_q      <= '0;
								iss_done_q <= 1'b0;
								state_q    <= ST_SCAN;
							end
						end else if (!is_cr) begin
							if (full) begin
								cnt_ov_q <= cnt_ov_q + 1'b1;
								len_q    <= '0;
								ev_q     <= EV_OVERFLOW;
								state_q  <= ST_EMIT;
							end else begin
								len_q <= len_q + 1'b1;
							end
						end
					end
				end
				ST_SCAN: begin
					if (!iss_done_q) begin
						vld_s1 <= 1'b1;
						if (cnt_q == len_q - 1'b1) begin
							iss_done_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (!vld_s1) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					len_q <= '0;
					if (!res.is_rmc) begin
						state_q <= ST_IDLE;
					end else if (!res.csum_ok) begin
						cnt_cs_q <= cnt_cs_q + 1'b1;
						ev_q     <= EV_CSUM_FAIL;
						state_q  <= ST_EMIT;
					end else if (res.parse_ok) begin
						last_q  <= res.stamp;
						have_q  <= 1'b1;
						state_q <= ST_CONV;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						unix_q <= ticks;
						if (ev_q == EV_PPS_LOCK) begin
							lock_q <= 1'b1;
						end else begin
							cnt_ok_q <= cnt_ok_q + 1'b1;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			// The event kind of a conversion is fixed when it starts.
			if (conv_go) begin
				ev_q <= (state_q == ST_IDLE) ? EV_PPS_LOCK : EV_RMC_OK;
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= cnt_q;
		if (emit_load) begin
			out_ev_q    <= ev_q;
			out_time_q  <= unix_q;
			out_stamp_q <= last_q;
			out_lock_q  <= lock_q;
			case (ev_q)
				EV_RMC_OK:    out_cnt_q <= cnt_ok_q;
				EV_CSUM_FAIL: out_cnt_q <= cnt_cs_q;
				EV_OVERFLOW:  out_cnt_q <= cnt_ov_q;
				default:      out_cnt_q <= '0;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = out_ev_q;
	assign unix_time_100us = out_time_q;
	assign year            = out_stamp_q.year;
	assign month           = out_stamp_q.month;
	assign day             = out_stamp_q.day;
	assign hours           = out_stamp_q.hours;
	assign minutes         = out_stamp_q.minutes;
	assign seconds         = out_stamp_q.seconds;
	assign milliseconds    = out_stamp_q.milliseconds;
	assign gps_fix         = out_stamp_q.gps_fix;
	assign locked          = out_lock_q;
	assign event_count     = out_cnt_q;

	`ASSERT_IMPL(a_lock_evt, out_valid_q && out_ev_q == EV_PPS_LOCK, out_lock_q)
	`ASSERT_IMPL(a_pps_cnt_zero, out_valid_q && out_ev_q >= EV_PPS_LOCK, out_cnt_q == '0)
	`ASSERT_IMPL(a_rmc_year, out_valid_q && out_ev_q == EV_RMC_OK, year >= 12'(YEAR_BASE))
	`ASSERT_NEXT(a_conv_to_emit, state_q == ST_CONV && conv_done, state_q == ST_EMIT)

endmodule

// ----- rtl/rmc_line_buf.sv -----
// Line buffer memory: one write port and one registered read port.
module rmc_line_buf (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [rmc_pkg::LINE_AW-1:0] wr_addr,
	input  logic [7:0]                  wr_data,
	input  logic [rmc_pkg::LINE_AW-1:0] rd_addr,
	output logic [7:0]                  rd_data
);
	import rmc_pkg::*;

	logic [7:0] line_mem_q [LINE_CAPACITY];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= line_mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/rmc_scan.sv -----
// Sentence scanner: header, checksum and field extraction, one byte per cycle.
module rmc_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  rmc_pkg::scan_beat_t beat,
	output rmc_pkg::scan_res_t  res
);
	import rmc_pkg::*;

	localparam logic [3:0] FLD_TIME   = 4'd1;
	localparam logic [3:0] FLD_STATUS = 4'd2;
	localparam logic [3:0] FLD_DATE   = 4'd9;

	logic [3:0]      hdr_q;
	logic            star_q;
	logic [7:0]      xsum_q;
	logic [1:0]      aft_q;
	logic [7:0]      hi_q, lo_q;
	logic [3:0]      cc_q;
	logic            infld_q;
	logic [FL_W-1:0] tl_q, sl_q, dl_q;
	logic            dot_q;
	logic [1:0]      ad_q;
	logic            fix_q;
	logic [7:0]      tdig_q [6];
	logic [7:0]      frac_q [2];
	logic [7:0]      ddig_q [6];

	logic [7:0] c;
	logic       fchar;

	assign c     = beat.data;
	assign fchar = infld_q && (c != CH_COMMA) && (c != CH_STAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= '0;
			star_q  <= 1'b0;
			xsum_q  <= '0;
			aft_q   <= '0;
			cc_q    <= '0;
			infld_q <= 1'b0;
			tl_q    <= '0;
			sl_q    <= '0;
			dl_q    <= '0;
			dot_q   <= 1'b0;
			ad_q    <= '0;
			fix_q   <= 1'b0;
		end else if (clr) begin
			hdr_q   <= '0;
			star_q  <= 1'b0;
			xsum_q  <= '0;
			aft_q   <= '0;
			cc_q    <= '0;
			infld_q <= 1'b0;
			tl_q    <= '0;
			sl_q    <= '0;
			dl_q    <= '0;
			dot_q   <= 1'b0;
			ad_q    <= '0;
			fix_q   <= 1'b0;
		end else if (beat.vld) begin
			if (beat.pos == LINE_AW'(0)) hdr_q[0] <= (c == CH_DOLLAR);
			if (beat.pos == LINE_AW'(3)) hdr_q[1] <= (c == CH_R);
			if (beat.pos == LINE_AW'(4)) hdr_q[2] <= (c == CH_M);
			if (beat.pos == LINE_AW'(5)) hdr_q[3] <= (c == CH_C);

			// The checksum covers everything between the dollar and the first star.
			if (!star_q) begin
				if (c == CH_STAR) begin
					star_q <= 1'b1;
				end else if (beat.pos != LINE_AW'(0)) begin
					xsum_q <= xsum_q ^ c;
				end
			end else if (aft_q != 2'd2) begin
				aft_q <= aft_q + 2'd1;
			end

			// Commas count fields even after a star; a star only ends the field.
			if (c == CH_COMMA) begin
				if (cc_q != 4'hF) cc_q <= cc_q + 4'd1;
				infld_q <= 1'b1;
			end else if (c == CH_STAR) begin
				infld_q <= 1'b0;
			end else if (fchar) begin
				case (cc_q)
					FLD_TIME: begin
						if (tl_q != '1) tl_q <= tl_q + 1'b1;
						if (!dot_q && c == CH_DOT) begin
							dot_q <= 1'b1;
						end else if (dot_q) begin
							if (ad_q != 2'd3) ad_q <= ad_q + 2'd1;
						end
					end
					FLD_STATUS: begin
						if (sl_q == '0) fix_q <= (c == CH_A);
						if (sl_q != '1) sl_q <= sl_q + 1'b1;
					end
					FLD_DATE: begin
						if (dl_q != '1) dl_q <= dl_q + 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat.vld && star_q) begin
			if (aft_q == 2'd0) hi_q <= c;
			if (aft_q == 2'd1) lo_q <= c;
		end
		if (!clr && beat.vld && fchar) begin
			if (cc_q == FLD_TIME) begin
				if (tl_q < FL_W'(6)) tdig_q[tl_q[2:0]] <= c;
				if (dot_q && ad_q < 2'd2) frac_q[ad_q[0]] <= c;
			end
			if (cc_q == FLD_DATE && dl_q < FL_W'(6)) ddig_q[dl_q[2:0]] <= c;
		end
	end

	logic [4:0] hv, lv;
	logic       frac_use, time_dig, date_dig, frac_dig;

	always_comb begin
		hv       = hex_val(hi_q);
		lv       = hex_val(lo_q);
		frac_use = dot_q && (ad_q >= 2'd2);
		time_dig = 1'b1;
		date_dig = 1'b1;
		for (int i = 0; i < 6; i++) begin
			time_dig = time_dig & is_digit(tdig_q[i]);
			date_dig = date_dig & is_digit(ddig_q[i]);
		end
		frac_dig = is_digit(frac_q[0]) && is_digit(frac_q[1]);

		res.is_rmc   = &hdr_q;
		res.csum_ok  = star_q && (aft_q == 2'd2) && hv[4] && lv[4] &&
			(xsum_q == {hv[3:0], lv[3:0]});
		res.parse_ok = (cc_q >= FLD_DATE) && (tl_q >= FL_W'(6)) &&
			(tl_q < FL_W'(FIELD_CAPACITY)) && (sl_q < FL_W'(FIELD_CAPACITY)) &&
			(dl_q == FL_W'(6)) && time_dig && date_dig && (!frac_use || frac_dig);

		res.stamp.hours        = digit_pair(tdig_q[0], tdig_q[1]);
		res.stamp.minutes      = digit_pair(tdig_q[2], tdig_q[3]);
		res.stamp.seconds      = digit_pair(tdig_q[4], tdig_q[5]);
		res.stamp.milliseconds = frac_use ?
			10'({3'b000, digit_pair(frac_q[0], frac_q[1])} * 10'd10) : 10'd0;
		res.stamp.day          = digit_pair(ddig_q[0], ddig_q[1]);
		res.stamp.month        = digit_pair(ddig_q[2], ddig_q[3]);
		res.stamp.year         = 12'(YEAR_BASE) + {5'b00000, digit_pair(ddig_q[4], ddig_q[5])};
		res.stamp.gps_fix      = (sl_q != '0) && fix_q;
	end

endmodule

// ----- rtl/rmc_tconv.sv -----
// Date and time to Unix ticks: one shared multiply-add unit stepped five times.
module rmc_tconv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       pps,
	input  rmc_pkg::stamp_t            stamp,
	output logic                       done,
	output logic [rmc_pkg::TICK_W-1:0] ticks
);
	import rmc_pkg::*;

	typedef enum logic [4:0] {
		STEP_DAYS    = 5'b00001,
		STEP_HOURS   = 5'b00010,
		STEP_MINUTES = 5'b00100,
		STEP_SECONDS = 5'b01000,
		STEP_TICKS   = 5'b10000
	} step_t;

	step_t             step_q;
	logic              busy_q, done_q, pps_q;
	logic [TICK_W-1:0] acc_q, dadd_q;

	// Setup of the day count: shifted year and month, era offset and day of era.
	logic              month_le2, era5;
	logic [11:0]       y;
	logic [8:0]        yoe;
	logic [6:0]        mp;
	logic [1:0]        c100;
	logic [TICK_W-1:0] dadd;

	always_comb begin
		month_le2 = (stamp.month <= 7'd2);
		y         = stamp.year - {11'd0, month_le2};
		era5      = (y >= 12'(YEAR_BASE));
		yoe       = era5 ? 9'(y - 12'(YEAR_BASE)) : 9'(y - 12'(PREV_ERA_YEAR));
		mp        = month_le2 ? 7'(stamp.month + 7'd9) : 7'(stamp.month - 7'd3);
		if (yoe >= 9'd300)      c100 = 2'd3;
		else if (yoe >= 9'd200) c100 = 2'd2;
		else if (yoe >= 9'd100) c100 = 2'd1;
		else                    c100 = 2'd0;
		dadd = (era5 ? DAYS_ERA5 : DAYS_ERA4) + TICK_W'(yoe >> 2) - TICK_W'(c100) +
			TICK_W'(DOY_TAB[mp]) + TICK_W'(stamp.day) - TICK_W'(1);
	end

	logic [13:0]         mul_c;
	logic [TICK_W-1:0]   add_c;
	logic [TICK_W+13:0]  prod;

	always_comb begin
		case (step_q)
			STEP_DAYS: begin
				mul_c = MUL_YEAR;
				add_c = dadd_q;
			end
			STEP_HOURS: begin
				mul_c = MUL_DAY;
				add_c = TICK_W'(stamp.hours);
			end
			STEP_MINUTES: begin
				mul_c = MUL_MIN;
				add_c = TICK_W'(stamp.minutes);
			end
			STEP_SECONDS: begin
				mul_c = MUL_MIN;
				add_c = TICK_W'(stamp.seconds);
			end
			default: begin
				mul_c = MUL_TICK;
				// A pulse lands on the next whole second, dropping the fraction.
				add_c = pps_q ? TICK_W'(TICKS_PER_SEC) :
					TICK_W'({4'd0, stamp.milliseconds} * 14'd10);
			end
		endcase
		prod = (TICK_W + 14)'(acc_q) * (TICK_W + 14)'(mul_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_DAYS;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_DAYS;
			end else if (busy_q) begin
				case (step_q)
					STEP_DAYS:    step_q <= STEP_HOURS;
					STEP_HOURS:   step_q <= STEP_MINUTES;
					STEP_MINUTES: step_q <= STEP_SECONDS;
					STEP_SECONDS: step_q <= STEP_TICKS;
					default: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= TICK_W'(yoe);
			dadd_q <= dadd;
			pps_q  <= pps;
		end else if (busy_q) begin
			acc_q <= prod[TICK_W-1:0] + add_c;
		end
	end

	assign done  = done_q;
	assign ticks = acc_q;

endmodule
